// ----- rtl/rct_pkg.sv -----
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types, codes and constants of the ratio calibration tracker.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int MAX_SAMPLES = 32;
  localparam int SLOT_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int REG_W       = 6;
  localparam int CMP_W       = ((CNT_W > REG_W) ? CNT_W : REG_W) + 1;

  localparam int HR_W    = 12;
  localparam int RM_W    = 16;
  localparam int Q_W     = 16;
  localparam int CONF_W  = 15;
  localparam int FRAC_W  = 14;
  localparam logic [Q_W-1:0] Q_ONE = 16'd16384;

  // One entry: hr ok, hr ratio, rmssd ok, rmssd ratio
  localparam int ENTRY_W = 2 * (Q_W + 1);

  localparam int DIV_W     = 32;
  localparam int DVS_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int SUM_W     = 32;
  localparam int TOT_W     = 16;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CORRECT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  localparam logic REG_MIN  = 1'b0;
  localparam logic REG_FULL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_HR_DIV,
    S_RM_DIV,
    S_WRITE,
    S_WALK,
    S_HF_DIV,
    S_RF_DIV,
    S_MUL,
    S_CONF,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Add an offset to a slot, wrapping at the window depth
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(MAX_SAMPLES)) begin
      sum = sum - (CNT_W + 1)'(MAX_SAMPLES);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

// ----- rtl/rct_if.sv -----
// ----------------------------------------------------------------------------
// rct_if
// Request and result channels of the ratio calibration tracker.
// ----------------------------------------------------------------------------
interface rct_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [rct_pkg::HR_W-1:0]  finger_hr;
  logic [rct_pkg::HR_W-1:0]  face_hr;
  logic [rct_pkg::RM_W-1:0]  finger_rmssd;
  logic [rct_pkg::RM_W-1:0]  face_rmssd;

  modport source (output valid, cmd, finger_hr, face_hr, finger_rmssd, face_rmssd,
                  input ready);
  modport sink   (input valid, cmd, finger_hr, face_hr, finger_rmssd, face_rmssd,
                  output ready);
endinterface

interface rct_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [rct_pkg::HR_W-1:0]    corrected_hr;
  logic [rct_pkg::RM_W-1:0]    corrected_rmssd;
  logic [rct_pkg::Q_W-1:0]     hr_factor_out;
  logic [rct_pkg::Q_W-1:0]     rmssd_factor_out;
  logic                        calibrated_out;
  logic [rct_pkg::REG_W-1:0]   window_count;
  logic [rct_pkg::CONF_W-1:0]  confidence;

  modport source (output valid, accepted, corrected_hr, corrected_rmssd, hr_factor_out,
                  rmssd_factor_out, calibrated_out, window_count, confidence,
                  input ready);
  modport sink   (input valid, accepted, corrected_hr, corrected_rmssd, hr_factor_out,
                  rmssd_factor_out, calibrated_out, window_count, confidence,
                  output ready);
endinterface

// ----- rtl/ratio_calibration_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// ratio_calibration_tracker_unit
// Rolling window of reference/face ratios and weighted-mean correction.
// ----------------------------------------------------------------------------
// One request at a time. Each division runs on the shared bit-serial divider.
// A correct-only or clear request spends most of its time in the confidence
// division. An add takes up to two divisions for the ratios (an out-of-range
// ratio skips its division), then, once the window holds min_samples pairs,
// a walk over the ratio RAM and two more divisions for the factors, then the
// confidence division. The result sits in an output register, so the next
// request is taken while it waits. Entries are valid once written; the fill
// count keeps unwritten entries out of every sum.
module ratio_calibration_tracker_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic                       wr_index,
  input  logic [rct_pkg::REG_W-1:0]  wr_data,
  rct_in_if.sink                     req_ch,
  rct_out_if.source                  rsp_ch
);

  localparam int SW = rct_pkg::SLOT_W;
  localparam int CW = rct_pkg::CNT_W;
  localparam int QW = rct_pkg::Q_W;

  rct_pkg::state_t state, state_next;

  logic [rct_pkg::REG_W-1:0] min_samples, full_samples;
  logic [1:0]                cmd_q;
  logic [rct_pkg::HR_W-1:0]  fhr_q, chr_q;
  logic [rct_pkg::RM_W-1:0]  frm_q, crm_q;
  logic                      hr_ok_q, rm_ok_q;
  logic [QW-1:0]             hr_ratio_q, rm_ratio_q;
  logic [SW-1:0]             oldest;
  logic [CW-1:0]             fill;
  logic [QW-1:0]             hr_factor, rm_factor;
  logic                      calibrated;
  logic                      accepted_q;
  logic [CW-1:0]             idx;
  logic                      rd_vld;
  logic [CW-1:0]             hr_w, rm_w;
  logic [rct_pkg::SUM_W-1:0] hr_sum, rm_sum;
  logic [rct_pkg::TOT_W-1:0] hr_tot, rm_tot;
  logic                      div_pend;
  logic [27:0]               prod_hr;
  logic [31:0]               prod_rm;
  logic [rct_pkg::CONF_W-1:0] conf_q;

  logic                      out_valid;
  logic                      out_free;
  logic                      in_take;

  logic                      hr_in_range, rm_in_range;
  logic [SW-1:0]             wr_slot, rd_slot;
  logic [CW-1:0]             fill_after;
  logic                      reach_min;
  logic                      below_min;
  logic [CW-1:0]             hr_w_inc, rm_w_inc;

  logic                      ram_we;
  logic [rct_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic                      rd_hr_ok, rd_rm_ok;
  logic [QW-1:0]             rd_hr, rd_rm;

  rct_pkg::div_req_t div_req;
  rct_pkg::div_rsp_t div_rsp;

  assign out_free = !out_valid || rsp_ch.ready;
  assign in_take  = req_ch.valid && req_ch.ready;
  assign req_ch.ready = (state == rct_pkg::S_IDLE);

  // Exact range tests on the captured pair
  assign hr_in_range = ({4'b0, fhr_q} * 16'd10 >= {4'b0, chr_q} * 16'd7) &&
                       ({4'b0, fhr_q} * 16'd10 <= {4'b0, chr_q} * 16'd13);
  assign rm_in_range = (crm_q != '0) &&
                       ({frm_q, 1'b0} >= {1'b0, crm_q}) &&
                       ({1'b0, frm_q} <= {crm_q, 1'b0});

  assign wr_slot    = (fill < CW'(rct_pkg::MAX_SAMPLES)) ? rct_pkg::slot_wrap(oldest, fill)
                                                         : oldest;
  assign fill_after = (fill < CW'(rct_pkg::MAX_SAMPLES)) ? fill + 1'b1 : fill;
  assign reach_min  = rct_pkg::CMP_W'(fill_after) >= rct_pkg::CMP_W'(min_samples);
  assign below_min  = rct_pkg::CMP_W'(fill) < rct_pkg::CMP_W'(min_samples);
  assign rd_slot    = rct_pkg::slot_wrap(oldest, idx);

  assign ram_we    = (state == rct_pkg::S_WRITE);
  assign ram_wdata = {hr_ok_q, hr_ratio_q, rm_ok_q, rm_ratio_q};
  assign {rd_hr_ok, rd_hr, rd_rm_ok, rd_rm} = ram_rdata;
  assign hr_w_inc  = hr_w + 1'b1;
  assign rm_w_inc  = rm_w + 1'b1;

  rct_ram #(
    .WIDTH (rct_pkg::ENTRY_W),
    .DEPTH (rct_pkg::MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_slot),
    .wdata (ram_wdata),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  rct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Divider requests for whichever division the current state needs
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      rct_pkg::S_HR_DIV: begin
        div_req.start    = !div_pend && hr_in_range;
        div_req.dividend = {6'b0, fhr_q, 14'b0};
        div_req.divisor  = {4'b0, chr_q};
      end
      rct_pkg::S_RM_DIV: begin
        div_req.start    = !div_pend && rm_in_range;
        div_req.dividend = {2'b0, frm_q, 14'b0};
        div_req.divisor  = crm_q;
      end
      rct_pkg::S_HF_DIV: begin
        div_req.start    = !div_pend && (hr_tot != '0);
        div_req.dividend = hr_sum;
        div_req.divisor  = hr_tot;
      end
      rct_pkg::S_RF_DIV: begin
        div_req.start    = !div_pend && (rm_tot != '0);
        div_req.dividend = rm_sum;
        div_req.divisor  = rm_tot;
      end
      rct_pkg::S_CONF: begin
        div_req.start    = !div_pend && (below_min || (full_samples != '0));
        div_req.dividend = rct_pkg::DIV_W'({fill, 14'b0});
        div_req.divisor  = below_min ? rct_pkg::DVS_W'(min_samples)
                                     : rct_pkg::DVS_W'(full_samples);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      rct_pkg::S_IDLE: begin
        if (in_take) begin
          if (req_ch.cmd == rct_pkg::CMD_CLEAR) begin
            state_next = rct_pkg::S_CLEAR;
          end else if (req_ch.cmd == rct_pkg::CMD_ADD && req_ch.finger_hr != '0 &&
                       req_ch.face_hr != '0) begin
            state_next = rct_pkg::S_HR_DIV;
          end else begin
            state_next = rct_pkg::S_MUL;
          end
        end
      end
      rct_pkg::S_CLEAR: state_next = rct_pkg::S_MUL;
      rct_pkg::S_HR_DIV: begin
        if (!hr_in_range || div_rsp.done) state_next = rct_pkg::S_RM_DIV;
      end
      rct_pkg::S_RM_DIV: begin
        if (!rm_in_range || div_rsp.done) state_next = rct_pkg::S_WRITE;
      end
      rct_pkg::S_WRITE: state_next = reach_min ? rct_pkg::S_WALK : rct_pkg::S_MUL;
      rct_pkg::S_WALK: begin
        if (idx == fill && !rd_vld) state_next = rct_pkg::S_HF_DIV;
      end
      rct_pkg::S_HF_DIV: begin
        if (hr_tot == '0 || div_rsp.done) state_next = rct_pkg::S_RF_DIV;
      end
      rct_pkg::S_RF_DIV: begin
        if (rm_tot == '0 || div_rsp.done) state_next = rct_pkg::S_MUL;
      end
      rct_pkg::S_MUL: state_next = rct_pkg::S_CONF;
      rct_pkg::S_CONF: begin
        if ((!below_min && full_samples == '0) || div_rsp.done) state_next = rct_pkg::S_OUT;
      end
      rct_pkg::S_OUT: begin
        if (out_free) state_next = rct_pkg::S_IDLE;
      end
      default: state_next = rct_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples  <= 6'd5;
      full_samples <= 6'd20;
    end else if (wr_en) begin
      if (wr_index == rct_pkg::REG_MIN) begin
        min_samples <= wr_data;
      end else begin
        full_samples <= wr_data;
      end
    end
  end

  // Window and factor state
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      fill       <= '0;
      hr_factor  <= rct_pkg::Q_ONE;
      rm_factor  <= rct_pkg::Q_ONE;
      calibrated <= 1'b0;
      div_pend   <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (div_req.start) begin
        div_pend <= 1'b1;
      end else if (div_rsp.done) begin
        div_pend <= 1'b0;
      end
      case (state)
        rct_pkg::S_CLEAR: begin
          oldest     <= '0;
          fill       <= '0;
          hr_factor  <= rct_pkg::Q_ONE;
          rm_factor  <= rct_pkg::Q_ONE;
          calibrated <= 1'b0;
        end
        rct_pkg::S_WRITE: begin
          fill <= fill_after;
          if (fill == CW'(rct_pkg::MAX_SAMPLES)) begin
            oldest <= rct_pkg::slot_wrap(oldest, CW'(1));
          end
          if (reach_min) begin
            calibrated <= 1'b1;
          end
          rd_vld <= 1'b0;
        end
        rct_pkg::S_WALK: begin
          rd_vld <= (idx != fill);
        end
        rct_pkg::S_HF_DIV: begin
          if (div_rsp.done) hr_factor <= div_rsp.quotient[QW-1:0];
        end
        rct_pkg::S_RF_DIV: begin
          if (div_rsp.done) rm_factor <= div_rsp.quotient[QW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q      <= req_ch.cmd;
      fhr_q      <= req_ch.finger_hr;
      chr_q      <= req_ch.face_hr;
      frm_q      <= req_ch.finger_rmssd;
      crm_q      <= req_ch.face_rmssd;
      accepted_q <= 1'b0;
    end
    case (state)
      rct_pkg::S_HR_DIV: begin
        accepted_q <= 1'b1;
        hr_ok_q    <= hr_in_range;
        if (!hr_in_range) hr_ratio_q <= '0;
        else if (div_rsp.done) hr_ratio_q <= div_rsp.quotient[QW-1:0];
      end
      rct_pkg::S_RM_DIV: begin
        rm_ok_q <= rm_in_range;
        if (!rm_in_range) rm_ratio_q <= '0;
        else if (div_rsp.done) rm_ratio_q <= div_rsp.quotient[QW-1:0];
      end
      rct_pkg::S_WRITE: begin
        idx    <= '0;
        hr_w   <= '0;
        rm_w   <= '0;
        hr_sum <= '0;
        rm_sum <= '0;
        hr_tot <= '0;
        rm_tot <= '0;
      end
      rct_pkg::S_WALK: begin
        if (idx != fill) idx <= idx + 1'b1;
        // Accumulate the entry read last cycle; weights count valid ones only
        if (rd_vld && rd_hr_ok) begin
          hr_w   <= hr_w_inc;
          hr_sum <= hr_sum + rct_pkg::SUM_W'(rd_hr) * rct_pkg::SUM_W'(hr_w_inc);
          hr_tot <= hr_tot + rct_pkg::TOT_W'(hr_w_inc);
        end
        if (rd_vld && rd_rm_ok) begin
          rm_w   <= rm_w_inc;
          rm_sum <= rm_sum + rct_pkg::SUM_W'(rd_rm) * rct_pkg::SUM_W'(rm_w_inc);
          rm_tot <= rm_tot + rct_pkg::TOT_W'(rm_w_inc);
        end
      end
      rct_pkg::S_MUL: begin
        prod_hr <= {16'b0, chr_q} * {12'b0, hr_factor};
        prod_rm <= {16'b0, crm_q} * {16'b0, rm_factor};
      end
      rct_pkg::S_CONF: begin
        if (!below_min && full_samples == '0) begin
          conf_q <= rct_pkg::CONF_W'(rct_pkg::Q_ONE);
        end else if (div_rsp.done) begin
          if (div_rsp.quotient > rct_pkg::DIV_W'(rct_pkg::Q_ONE)) begin
            conf_q <= rct_pkg::CONF_W'(rct_pkg::Q_ONE);
          end else begin
            conf_q <= div_rsp.quotient[rct_pkg::CONF_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rct_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rct_pkg::S_OUT && out_free) begin
      rsp_ch.accepted <= accepted_q && (cmd_q == rct_pkg::CMD_ADD);
      if (!calibrated) begin
        rsp_ch.corrected_hr    <= chr_q;
        rsp_ch.corrected_rmssd <= crm_q;
      end else begin
        rsp_ch.corrected_hr    <= (prod_hr[27:26] != '0) ? '1 : prod_hr[25:14];
        rsp_ch.corrected_rmssd <= (prod_rm[31:30] != '0) ? '1 : prod_rm[29:14];
      end
      rsp_ch.hr_factor_out    <= hr_factor;
      rsp_ch.rmssd_factor_out <= rm_factor;
      rsp_ch.calibrated_out   <= calibrated;
      rsp_ch.window_count     <= rct_pkg::REG_W'(fill);
      rsp_ch.confidence       <= conf_q;
    end
  end

  assign rsp_ch.valid = out_valid;

endmodule

// ----- rtl/rct_ram.sv -----
// ----------------------------------------------------------------------------
// rct_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rct_div.sv -----
// ----------------------------------------------------------------------------
// rct_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module rct_div (
  input  logic              clk,
  input  logic              rst,
  input  rct_pkg::div_req_t req,
  output rct_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic [rct_pkg::DIV_CNT_W-1:0]     cnt;
  logic [rct_pkg::DVS_W-1:0]         rem;
  logic [rct_pkg::DIV_W-1:0]         quo;
  logic [rct_pkg::DVS_W-1:0]         dvs;
  logic                              done;
  logic [rct_pkg::DVS_W:0]           trial;
  logic                              fits;

  assign trial = {rem, quo[rct_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        quo <= {quo[rct_pkg::DIV_W-2:0], fits};
        if (fits) begin
          rem <= rct_pkg::DVS_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[rct_pkg::DVS_W-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == rct_pkg::DIV_CNT_W'(rct_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- rtl/rct_checker.sv -----
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks of the ratio calibration tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rct_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        accepted,
  input logic [rct_pkg::Q_W-1:0]     hr_factor_out,
  input logic [rct_pkg::Q_W-1:0]     rmssd_factor_out,
  input logic                        calibrated_out,
  input logic [rct_pkg::REG_W-1:0]   window_count,
  input logic [rct_pkg::CONF_W-1:0]  confidence
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_count <= rct_pkg::REG_W'(rct_pkg::MAX_SAMPLES))
    else $error("window count beyond depth");

  a_conf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> confidence <= rct_pkg::CONF_W'(rct_pkg::Q_ONE))
    else $error("confidence above one");

  // Factors move only after calibration
  a_uncal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !calibrated_out |->
      hr_factor_out == rct_pkg::Q_ONE && rmssd_factor_out == rct_pkg::Q_ONE)
    else $error("factor changed while uncalibrated");

  a_stored: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> window_count != '0)
    else $error("stored request left window empty");

endmodule

bind ratio_calibration_tracker_unit rct_checker u_rct_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (rsp_ch.valid),
  .out_ready        (rsp_ch.ready),
  .accepted         (rsp_ch.accepted),
  .hr_factor_out    (rsp_ch.hr_factor_out),
  .rmssd_factor_out (rsp_ch.rmssd_factor_out),
  .calibrated_out   (rsp_ch.calibrated_out),
  .window_count     (rsp_ch.window_count),
  .confidence       (rsp_ch.confidence)
);
